### design/rpf_pkg.sv
// Shared widths, register codes and payload types for the repulsive potential field block.
package rpf_pkg;

    localparam int LANES     = 3;
    localparam int POS_W     = 24;
    localparam int DIFF_W    = 25;
    localparam int MAG_W     = 25;
    localparam int SQ1_W     = 49;
    localparam int SQ_W      = 50;
    localparam int ROOT_W    = 25;
    localparam int REM_W     = 26;
    localparam int STR_W     = 16;
    localparam int CFG_W     = 23;
    localparam int CFG_IDX_W = 2;
    localparam int DIST_W    = 26;
    localparam int DMAG_W    = 23;
    localparam int GAP_W     = 24;
    localparam int SGAP_W    = 40;
    localparam int DC_W      = 46;
    localparam int DL_W      = 48;
    localparam int DL_LO_W   = 24;
    localparam int PP_W      = 70;
    localparam int DEN_W     = 94;
    localparam int NUM_W     = 65;
    localparam int Q_W       = 33;
    localparam int ACC_W     = 32;

    localparam logic [STR_W-1:0] STRENGTH_RST = 16'd328;
    localparam logic [CFG_W-1:0] CUTOFF_RST   = 23'd6554;
    localparam logic [CFG_W-1:0] RADIUS_RST   = 23'd66;

    localparam logic [Q_W-1:0]   LIM_POS = 33'h0_7FFF_FFFF;
    localparam logic [Q_W-1:0]   LIM_NEG = 33'h0_8000_0000;
    localparam logic [ACC_W-1:0] ACC_MAX = 32'h7FFF_FFFF;
    localparam logic [ACC_W-1:0] ACC_MIN = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STRENGTH = 2'd0,
        CFG_CUTOFF   = 2'd1,
        CFG_RADIUS   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][MAG_W-1:0] mag;
    } t_geo;

    typedef struct packed {
        logic             in_range;
        logic             zero_len;
        logic             on_surf;
        logic [LANES-1:0] neg;
        logic [LANES-1:0] nz;
    } t_fin;

    typedef struct packed {
        logic signed [ACC_W-1:0] accel_x;
        logic signed [ACC_W-1:0] accel_y;
        logic signed [ACC_W-1:0] accel_z;
        logic                    in_range;
        logic                    saturated;
    } t_rsp;

endpackage

### design/rpf_req_if.sv
// Request channel: query point and obstacle centre.
interface rpf_req_if import rpf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] point_x;
    logic signed [POS_W-1:0] point_y;
    logic signed [POS_W-1:0] point_z;
    logic signed [POS_W-1:0] obstacle_x;
    logic signed [POS_W-1:0] obstacle_y;
    logic signed [POS_W-1:0] obstacle_z;

    modport source (output valid, point_x, point_y, point_z,
                    obstacle_x, obstacle_y, obstacle_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z,
                    obstacle_x, obstacle_y, obstacle_z, output ready);
endinterface

### design/rpf_rsp_if.sv
// Result channel: repulsive acceleration and flags.
interface rpf_rsp_if import rpf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] accel_x;
    logic signed [ACC_W-1:0] accel_y;
    logic signed [ACC_W-1:0] accel_z;
    logic                    in_range;
    logic                    saturated;

    modport source (output valid, accel_x, accel_y, accel_z, in_range, saturated,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, in_range, saturated,
                    output ready);
endinterface

### design/rpf_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module rpf_sqrt import rpf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [SQ_W-1:0]   i_rad,
    input  t_geo              i_geo,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_geo              o_geo
);

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SQ_W-1:0]   r_rad  [ROOT_W];
    t_geo              r_geo  [ROOT_W];
    logic              r_v    [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [SQ_W-1:0]   p_rad;
        t_geo              p_geo;
        logic              p_v;
        logic [REM_W+1:0]  trial;
        logic [REM_W+1:0]  tsub;
        logic              fit;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_geo  = i_geo;
            assign p_v    = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_geo  = r_geo[k-1];
            assign p_v    = r_v[k-1];
        end

        always_comb begin
            trial  = {p_rem, p_rad[SQ_W-1 -: 2]};
            tsub   = {1'b0, p_root, 2'b01};
            fit    = trial >= tsub;
            n_rem  = fit ? REM_W'(trial - tsub) : REM_W'(trial);
            n_root = {p_root[ROOT_W-2:0], fit};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_rad[k]  <= {p_rad[SQ_W-3:0], 2'b00};
                r_geo[k]  <= p_geo;
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_geo   = r_geo[ROOT_W-1];

endmodule

### design/rpf_scale.sv
// Surface distance, range test and the numerator and denominator products.
module rpf_scale import rpf_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [ROOT_W-1:0]           i_len,
    input  t_geo                        i_geo,
    input  logic [STR_W-1:0]            i_strength,
    input  logic [CFG_W-1:0]            i_cutoff,
    input  logic [CFG_W-1:0]            i_radius,
    output logic                        o_valid,
    output logic [LANES-1:0][NUM_W-1:0] o_num,
    output logic [DEN_W-1:0]            o_den,
    output t_fin                        o_fin
);

    logic signed [DIST_W-1:0] sdist;
    logic signed [DIST_W-1:0] cut;
    t_fin                     n_fin;

    always_comb begin
        sdist = signed'({1'b0, i_len}) - signed'({3'b000, i_radius});
        cut   = signed'({3'b000, i_cutoff});
        n_fin.in_range = (i_cutoff != '0) && (sdist < cut);
        n_fin.zero_len = (i_len == '0);
        n_fin.on_surf  = (sdist == '0);
        n_fin.neg      = i_geo.neg;
        for (int l = 0; l < LANES; l++) begin
            n_fin.nz[l] = (i_geo.mag[l] != '0);
        end
    end

    // distance stage
    logic                r_d_v;
    logic [DMAG_W-1:0]   r_d_dmag;
    logic [GAP_W-1:0]    r_d_gap;
    logic [ROOT_W-1:0]   r_d_len;
    t_geo                r_d_geo;
    t_fin                r_d_fin;
    // first products
    logic                r_m1_v;
    logic [SGAP_W-1:0]   r_m1_sgap;
    logic [DC_W-1:0]     r_m1_dc;
    logic [DL_W-1:0]     r_m1_dl;
    t_geo                r_m1_geo;
    t_fin                r_m1_fin;
    // numerators and denominator partial products
    logic                        r_m2_v;
    logic [PP_W-1:0]             r_m2_lo;
    logic [PP_W-1:0]             r_m2_hi;
    logic [LANES-1:0][NUM_W-1:0] r_m2_num;
    t_fin                        r_m2_fin;
    // denominator sum
    logic                        r_m3_v;
    logic [DEN_W-1:0]            r_m3_den;
    logic [LANES-1:0][NUM_W-1:0] r_m3_num;
    t_fin                        r_m3_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v  <= 1'b0;
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_m3_v <= 1'b0;
        end else if (i_en) begin
            r_d_v  <= i_valid;
            r_m1_v <= r_d_v;
            r_m2_v <= r_m1_v;
            r_m3_v <= r_m2_v;
        end
        if (i_en) begin
            r_d_dmag <= sdist[DIST_W-1] ? DMAG_W'(-sdist) : DMAG_W'(sdist);
            r_d_gap  <= GAP_W'(cut - sdist);
            r_d_len  <= i_len;
            r_d_geo  <= i_geo;
            r_d_fin  <= n_fin;

            r_m1_sgap <= SGAP_W'(i_strength * r_d_gap);
            r_m1_dc   <= DC_W'(r_d_dmag * i_cutoff);
            r_m1_dl   <= DL_W'(r_d_dmag * r_d_len);
            r_m1_geo  <= r_d_geo;
            r_m1_fin  <= r_d_fin;

            r_m2_lo  <= PP_W'(r_m1_dc * r_m1_dl[DL_LO_W-1:0]);
            r_m2_hi  <= PP_W'(r_m1_dc * r_m1_dl[DL_W-1:DL_LO_W]);
            for (int l = 0; l < LANES; l++) begin
                r_m2_num[l] <= NUM_W'(r_m1_sgap * r_m1_geo.mag[l]);
            end
            r_m2_fin <= r_m1_fin;

            r_m3_den <= DEN_W'(r_m2_lo) + (DEN_W'(r_m2_hi) << DL_LO_W);
            r_m3_num <= r_m2_num;
            r_m3_fin <= r_m2_fin;
        end
    end

    assign o_valid = r_m3_v;
    assign o_num   = r_m3_num;
    assign o_den   = r_m3_den;
    assign o_fin   = r_m3_fin;

endmodule

### design/rpf_div.sv
// Pipelined restoring divider, three lanes sharing one denominator, one bit per stage.
module rpf_div import rpf_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [LANES-1:0][NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]            i_den,
    input  t_fin                        i_fin,
    output logic                        o_valid,
    output logic [LANES-1:0][Q_W-1:0]   o_q,
    output logic [LANES-1:0]            o_ovf,
    output t_fin                        o_fin
);

    localparam int NW = NUM_W + 2 * FRAC_BITS;
    localparam int HW = NW - Q_W;

    logic [LANES-1:0][NW-1:0]    full;
    logic [LANES-1:0][DEN_W-1:0] n_p_rem;
    logic [LANES-1:0][Q_W-1:0]   n_p_low;
    logic [LANES-1:0]            n_p_ovf;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            full[l]    = {i_num[l], {(2 * FRAC_BITS){1'b0}}};
            n_p_rem[l] = {{(DEN_W - HW){1'b0}}, full[l][NW-1:Q_W]};
            n_p_low[l] = full[l][Q_W-1:0];
            n_p_ovf[l] = n_p_rem[l] >= i_den;
        end
    end

    logic                        r_p_v;
    logic [LANES-1:0][DEN_W-1:0] r_p_rem;
    logic [LANES-1:0][Q_W-1:0]   r_p_low;
    logic [LANES-1:0]            r_p_ovf;
    logic [DEN_W-1:0]            r_p_den;
    t_fin                        r_p_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (i_en) begin
            r_p_v <= i_valid;
        end
        if (i_en) begin
            r_p_rem <= n_p_rem;
            r_p_low <= n_p_low;
            r_p_ovf <= n_p_ovf;
            r_p_den <= i_den;
            r_p_fin <= i_fin;
        end
    end

    logic [LANES-1:0][DEN_W-1:0] r_rem [Q_W];
    logic [LANES-1:0][Q_W-1:0]   r_q   [Q_W];
    logic [LANES-1:0][Q_W-1:0]   r_low [Q_W];
    logic [LANES-1:0]            r_ovf [Q_W];
    logic [DEN_W-1:0]            r_den [Q_W];
    t_fin                        r_fin [Q_W];
    logic                        r_v   [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        logic [LANES-1:0][DEN_W-1:0] p_rem;
        logic [LANES-1:0][Q_W-1:0]   p_q;
        logic [LANES-1:0][Q_W-1:0]   p_low;
        logic [LANES-1:0]            p_ovf;
        logic [DEN_W-1:0]            p_den;
        t_fin                        p_fin;
        logic                        p_v;
        logic [LANES-1:0][DEN_W:0]   trial;
        logic [LANES-1:0]            fit;
        logic [LANES-1:0][DEN_W-1:0] n_rem;
        logic [LANES-1:0][Q_W-1:0]   n_q;
        logic [LANES-1:0][Q_W-1:0]   n_low;

        if (j == 0) begin : g_first
            assign p_rem = r_p_rem;
            assign p_q   = '0;
            assign p_low = r_p_low;
            assign p_ovf = r_p_ovf;
            assign p_den = r_p_den;
            assign p_fin = r_p_fin;
            assign p_v   = r_p_v;
        end else begin : g_next
            assign p_rem = r_rem[j-1];
            assign p_q   = r_q[j-1];
            assign p_low = r_low[j-1];
            assign p_ovf = r_ovf[j-1];
            assign p_den = r_den[j-1];
            assign p_fin = r_fin[j-1];
            assign p_v   = r_v[j-1];
        end

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                trial[l] = {p_rem[l], p_low[l][Q_W-1]};
                fit[l]   = trial[l] >= {1'b0, p_den};
                n_rem[l] = fit[l] ? DEN_W'(trial[l] - {1'b0, p_den}) : DEN_W'(trial[l]);
                n_q[l]   = {p_q[l][Q_W-2:0], fit[l]};
                n_low[l] = {p_low[l][Q_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= p_v;
            end
            if (i_en) begin
                r_rem[j] <= n_rem;
                r_q[j]   <= n_q;
                r_low[j] <= n_low;
                r_ovf[j] <= p_ovf;
                r_den[j] <= p_den;
                r_fin[j] <= p_fin;
            end
        end
    end

    assign o_valid = r_v[Q_W-1];
    assign o_q     = r_q[Q_W-1];
    assign o_ovf   = r_ovf[Q_W-1];
    assign o_fin   = r_fin[Q_W-1];

endmodule

### design/repulsive_potential_field.sv
// Top level of the repulsive potential field pipeline.
//
// Requests arrive on i_req (valid/ready): a query point and an obstacle centre,
// signed fixed point with POS_FRAC_BITS fraction bits. Each request gives one
// result on o_rsp (valid/ready): the repulsive acceleration in signed Q16.16,
// saturated, with in_range and saturated flags.
// Registers (strength, cutoff, obstacle radius) are written through i_cfg_we,
// i_cfg_idx and i_cfg_data; index 3 is ignored. Write them only while idle.
// Depth: 67 register stages, the last of them being the output register.
// Throughput: one request per cycle while the output does not stall. The depth
// comes from the square root, one root bit per stage (25 stages), and the
// divider, one quotient bit per stage (33 stages plus an overflow precheck).
// When o_rsp.ready is low the result holds in the output register; one more
// result lands in a skid register, then i_req.ready drops and the whole
// pipeline freezes until the output drains.
// Reset (synchronous, active low) empties the pipeline and restores the
// register defaults (strength 0.005, cutoff 0.1, radius 0.001).
module repulsive_potential_field import rpf_pkg::*; #(
    parameter int POS_FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rpf_req_if.sink              i_req,
    rpf_rsp_if.source            o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [STR_W-1:0] r_strength;
    logic [CFG_W-1:0] r_cutoff;
    logic [CFG_W-1:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strength <= STRENGTH_RST;
            r_cutoff   <= CUTOFF_RST;
            r_radius   <= RADIUS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_STRENGTH: r_strength <= i_cfg_data[STR_W-1:0];
                CFG_CUTOFF:   r_cutoff   <= i_cfg_data;
                CFG_RADIUS:   r_radius   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic r_out_v;
    logic r_skid_v;
    logic en;

    assign en          = !r_skid_v;
    assign i_req.ready = en && i_rst_n;

    // difference vector
    logic signed [DIFF_W-1:0] diff [LANES];
    t_geo                     n_geo;

    assign diff[0] = DIFF_W'(i_req.point_x) - DIFF_W'(i_req.obstacle_x);
    assign diff[1] = DIFF_W'(i_req.point_y) - DIFF_W'(i_req.obstacle_y);
    assign diff[2] = DIFF_W'(i_req.point_z) - DIFF_W'(i_req.obstacle_z);

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_geo.neg[l] = diff[l][DIFF_W-1];
            n_geo.mag[l] = diff[l][DIFF_W-1] ? MAG_W'(-diff[l]) : MAG_W'(diff[l]);
        end
    end

    logic             r_s1_v;
    t_geo             r_s1_geo;
    logic             r_s2_v;
    logic [SQ1_W-1:0] r_s2_sq [LANES];
    t_geo             r_s2_geo;
    logic             r_s3_v;
    logic [SQ_W-1:0]  r_s3_sum;
    t_geo             r_s3_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_req.valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
        if (en) begin
            r_s1_geo <= n_geo;
            for (int l = 0; l < LANES; l++) begin
                r_s2_sq[l] <= SQ1_W'(r_s1_geo.mag[l] * r_s1_geo.mag[l]);
            end
            r_s2_geo <= r_s1_geo;
            r_s3_sum <= SQ_W'(r_s2_sq[0]) + SQ_W'(r_s2_sq[1]) + SQ_W'(r_s2_sq[2]);
            r_s3_geo <= r_s2_geo;
        end
    end

    logic              sq_v;
    logic [ROOT_W-1:0] sq_root;
    t_geo              sq_geo;

    rpf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_v),
        .i_rad   (r_s3_sum),
        .i_geo   (r_s3_geo),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_geo   (sq_geo)
    );

    logic                        sc_v;
    logic [LANES-1:0][NUM_W-1:0] sc_num;
    logic [DEN_W-1:0]            sc_den;
    t_fin                        sc_fin;

    rpf_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (sq_v),
        .i_len      (sq_root),
        .i_geo      (sq_geo),
        .i_strength (r_strength),
        .i_cutoff   (r_cutoff),
        .i_radius   (r_radius),
        .o_valid    (sc_v),
        .o_num      (sc_num),
        .o_den      (sc_den),
        .o_fin      (sc_fin)
    );

    logic                      dv_v;
    logic [LANES-1:0][Q_W-1:0] dv_q;
    logic [LANES-1:0]          dv_ovf;
    t_fin                      dv_fin;

    rpf_div #(
        .FRAC_BITS (POS_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sc_v),
        .i_num   (sc_num),
        .i_den   (sc_den),
        .i_fin   (sc_fin),
        .o_valid (dv_v),
        .o_q     (dv_q),
        .o_ovf   (dv_ovf),
        .o_fin   (dv_fin)
    );

    // saturation and special cases
    t_rsp                        n_item;
    logic [LANES-1:0][Q_W-1:0]   lim;
    logic [LANES-1:0]            big;
    logic [LANES-1:0][ACC_W-1:0] mag32;
    logic [LANES-1:0][ACC_W-1:0] acc;
    logic                        sat;

    always_comb begin
        sat = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            lim[l]   = dv_fin.neg[l] ? LIM_NEG : LIM_POS;
            big[l]   = dv_ovf[l] || (dv_q[l] > lim[l]);
            mag32[l] = big[l] ? lim[l][ACC_W-1:0] : dv_q[l][ACC_W-1:0];
            if (!dv_fin.in_range || dv_fin.zero_len) begin
                acc[l] = '0;
            end else if (dv_fin.on_surf) begin
                acc[l] = !dv_fin.nz[l] ? '0 : (dv_fin.neg[l] ? ACC_MIN : ACC_MAX);
            end else begin
                acc[l] = dv_fin.neg[l] ? ACC_W'(-mag32[l]) : mag32[l];
                sat    = sat || big[l];
            end
        end
        if (dv_fin.in_range && (dv_fin.zero_len || dv_fin.on_surf)) begin
            sat = 1'b1;
        end
        n_item.accel_x   = acc[0];
        n_item.accel_y   = acc[1];
        n_item.accel_z   = acc[2];
        n_item.in_range  = dv_fin.in_range;
        n_item.saturated = sat;
    end

    // output register with skid
    t_rsp r_out;
    t_rsp r_skid;
    logic take;
    logic arrive;
    logic n_out_v;
    logic n_skid_v;

    assign take   = r_out_v && o_rsp.ready;
    assign arrive = en && dv_v;

    always_comb begin
        n_out_v  = r_out_v;
        n_skid_v = r_skid_v;
        if (take) begin
            n_out_v  = r_skid_v;
            n_skid_v = 1'b0;
        end
        if (arrive) begin
            if (!r_out_v || take) begin
                n_out_v = 1'b1;
            end else begin
                n_skid_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
        if (take && r_skid_v) begin
            r_out <= r_skid;
        end else if (arrive && (!r_out_v || take)) begin
            r_out <= n_item;
        end
        if (arrive && r_out_v && !take) begin
            r_skid <= n_item;
        end
    end

    assign o_rsp.valid     = r_out_v;
    assign o_rsp.accel_x   = r_out.accel_x;
    assign o_rsp.accel_y   = r_out.accel_y;
    assign o_rsp.accel_z   = r_out.accel_z;
    assign o_rsp.in_range  = r_out.in_range;
    assign o_rsp.saturated = r_out.saturated;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid holds a result while output register is empty");

    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.in_range) |->
        (o_rsp.accel_x == '0 && o_rsp.accel_y == '0 && o_rsp.accel_z == '0
         && !o_rsp.saturated))
        else $error("out of range result is not zero");

    a_stall_to_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !o_rsp.ready && en && dv_v) |=> r_skid_v)
        else $error("result arriving during stall was not kept");

endmodule
